// ===== rtl/core/imu_complementary_filter_top_assert.svh =====
// Assertion macros for the IMU complementary filter top level.
// Both forms sample on i_clk and stay quiet while i_rst_n is low.
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ICF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("imu filter: same-cycle check failed");

// next-cycle implication
`define ICF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("imu filter: next-cycle check failed");

`else

`define ICF_ASSERT_IMPL(label, ante, cons)
`define ICF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/icf_pkg.sv =====
package icf_pkg;

    // CORDIC datapath
    localparam int TAB_IDX_W = 5;
    localparam int CRD_FRAC  = 24;
    localparam int CRD_W     = 44;
    localparam int SEED_W    = 17;

    // integer square root of a 32-bit radicand, one result bit per cycle
    localparam int RAD_W    = 32;
    localparam int ROOT_W   = 16;
    localparam int REM_W    = 17;
    localparam int SQ_CNT_W = 5;
    localparam logic [SQ_CNT_W-1:0] SQ_STEPS = 5'd16;

    // shared multiplier and accumulator
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = 66;
    localparam int ACC_W   = 52;
    localparam int SUM_W   = 33;
    localparam int DELTA_W = 28;

    localparam logic signed [31:0]        DEG180_Q16  = 32'sd11796480;
    localparam logic signed [31:0]        RAD2DEG_Q24 = 32'sd961263669;
    localparam logic signed [MUL_P_W-1:0] GYRO_RND    = 66'sd34359738368;
    localparam int                        GYRO_SH     = 36;
    localparam logic [ACC_W-1:0]          MIX_RND     = 52'd32768;
    localparam int                        MIX_SH      = 16;
    localparam logic [15:0]               ALPHA_RESET = 16'd64225;
    localparam logic [16:0]               ALPHA_ONE   = 17'h10000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic        [15:0] step_time;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic               was_first;
    } t_result;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic signed [31:0] atan_deg_q16(input logic [TAB_IDX_W-1:0] idx);
        case (idx)
            5'd0:    atan_deg_q16 = 32'sd2949120;
            5'd1:    atan_deg_q16 = 32'sd1740967;
            5'd2:    atan_deg_q16 = 32'sd919879;
            5'd3:    atan_deg_q16 = 32'sd466945;
            5'd4:    atan_deg_q16 = 32'sd234379;
            5'd5:    atan_deg_q16 = 32'sd117304;
            5'd6:    atan_deg_q16 = 32'sd58666;
            5'd7:    atan_deg_q16 = 32'sd29335;
            5'd8:    atan_deg_q16 = 32'sd14668;
            5'd9:    atan_deg_q16 = 32'sd7334;
            5'd10:   atan_deg_q16 = 32'sd3667;
            5'd11:   atan_deg_q16 = 32'sd1833;
            5'd12:   atan_deg_q16 = 32'sd917;
            5'd13:   atan_deg_q16 = 32'sd458;
            5'd14:   atan_deg_q16 = 32'sd229;
            5'd15:   atan_deg_q16 = 32'sd115;
            5'd16:   atan_deg_q16 = 32'sd57;
            5'd17:   atan_deg_q16 = 32'sd29;
            5'd18:   atan_deg_q16 = 32'sd14;
            5'd19:   atan_deg_q16 = 32'sd7;
            5'd20:   atan_deg_q16 = 32'sd4;
            5'd21:   atan_deg_q16 = 32'sd2;
            5'd22:   atan_deg_q16 = 32'sd1;
            default: atan_deg_q16 = 32'sd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/icf_chan_if.sv =====
interface icf_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/imu_complementary_filter_top.sv =====
// Channel    Dir  Payload                                      Transfer
// i_sample   in   accel_x/y/z, rate_x/y/z, step_time (t_sample) valid & ready
// o_result   out  roll/pitch/yaw_angle, was_first (t_result)    valid & ready
// i_cfg      in   blend_weight, 16 bit                          valid & ready
//
// One sample passes the shared CORDIC stage, the bit-serial square root and the
// single multiplier before the next is taken; the first sample after reset skips the
// blend. i_sample.ready is low while a sample is at work. A finished result waits in
// the output register while the next sample is taken. Reset is synchronous, clears
// the filter state and reloads blend_weight.
`include "imu_complementary_filter_top_assert.svh"

module imu_complementary_filter_top
    import icf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icf_chan_if.sink    i_sample,
    icf_chan_if.source  o_result,
    icf_chan_if.sink    i_cfg
);

    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAG0  = 4'd1;
    localparam logic [3:0] ST_MAG1  = 4'd2;
    localparam logic [3:0] ST_MAG2  = 4'd3;
    localparam logic [3:0] ST_ROLL  = 4'd4;
    localparam logic [3:0] ST_PITCH = 4'd5;
    localparam logic [3:0] ST_BLEND = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    localparam logic [2:0] PH_RATE   = 3'd0;
    localparam logic [2:0] PH_SCALE  = 3'd1;
    localparam logic [2:0] PH_SUM    = 3'd2;
    localparam logic [2:0] PH_WEIGHT = 3'd3;
    localparam logic [2:0] PH_MIX    = 3'd4;
    localparam logic [2:0] PH_ROUND  = 3'd5;

    typedef struct packed {
        logic               zero;
        logic signed [31:0] z;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
    } t_cseed;

    function automatic t_cseed cordic_seed(input logic signed [SEED_W-1:0] y,
                                           input logic signed [SEED_W-1:0] x);
        t_cseed s;
        logic signed [SEED_W-1:0] xs;
        logic signed [SEED_W-1:0] ys;
        s.zero = (x == '0) && (y == '0);
        if (x[SEED_W-1]) begin
            xs  = -x;
            ys  = -y;
            s.z = y[SEED_W-1] ? -DEG180_Q16 : DEG180_Q16;
        end else begin
            xs  = x;
            ys  = y;
            s.z = '0;
        end
        s.x = $signed({{(CRD_W-SEED_W-CRD_FRAC){xs[SEED_W-1]}}, xs, {CRD_FRAC{1'b0}}});
        s.y = $signed({{(CRD_W-SEED_W-CRD_FRAC){ys[SEED_W-1]}}, ys, {CRD_FRAC{1'b0}}});
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] hi;
        hi = v[ACC_W-1:31];
        if (hi == '0 || hi == '1) begin
            sat32 = v[31:0];
        end else if (v[ACC_W-1]) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = 32'sh7FFFFFFF;
        end
    endfunction

    logic [3:0]   r_state, n_state;
    t_sample      r_in, n_in;
    logic [15:0]  r_alpha;
    logic         r_started, n_started;
    logic         r_first, n_first;
    logic signed [31:0] r_roll, n_roll;
    logic signed [31:0] r_pitch, n_pitch;
    logic signed [31:0] r_yaw, n_yaw;
    logic signed [31:0] r_roll_acc, n_roll_acc;
    logic signed [31:0] r_pitch_acc, n_pitch_acc;

    logic signed [CRD_W-1:0] r_cx, n_cx;
    logic signed [CRD_W-1:0] r_cy, n_cy;
    logic signed [31:0]      r_cz, n_cz;
    logic                    r_czero, n_czero;
    logic [STEP_W-1:0]       r_step, n_step;

    logic [RAD_W-1:0]    r_rad, n_rad;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [SQ_CNT_W-1:0] r_sq_cnt, n_sq_cnt;

    logic signed [MUL_P_W-1:0] r_mul;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [1:0]                r_axis, n_axis;
    logic [2:0]                r_phase, n_phase;

    t_result r_out;
    logic    r_out_valid;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                    crd_done;
    logic signed [31:0]      crd_res;
    logic signed [CRD_W-1:0] cx_sh, cy_sh;
    logic signed [31:0]      crd_tab;
    t_cseed                  seed;

    logic                  sq_done;
    logic [REM_W+1:0]      sq_cand, sq_trial;

    logic signed [MUL_P_W-1:0] gyro_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   store_sum;
    logic signed [ACC_W-1:0]   mix;
    logic signed [15:0]        cur_rate;
    logic signed [31:0]        cur_store;
    logic signed [31:0]        cur_acc;
    logic                      out_free;
    logic                      in_xfer;

    assign in_xfer         = i_sample.valid && i_sample.ready;
    assign i_sample.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out;
    assign out_free        = !r_out_valid || o_result.ready;

    assign mul_p = mul_a * mul_b;

    // shared CORDIC stage
    assign crd_done = (r_step == STEP_W'(CORDIC_STEPS));
    assign crd_res  = r_czero ? 32'sd0 : r_cz;
    assign cx_sh    = r_cx >>> r_step;
    assign cy_sh    = r_cy >>> r_step;
    assign crd_tab  = atan_deg_q16(TAB_IDX_W'(r_step));

    // bit-pair square root step
    assign sq_done  = (r_sq_cnt == '0);
    assign sq_cand  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    assign gyro_rnd  = (r_mul + GYRO_RND) >>> GYRO_SH;
    assign delta     = $signed(gyro_rnd[DELTA_W-1:0]);
    assign store_sum = SUM_W'(cur_store) + SUM_W'(delta);
    assign mix       = (r_acc + $signed(r_mul[ACC_W-1:0])) >>> MIX_SH;

    always_comb begin
        case (r_axis)
            AX_ROLL: begin
                cur_rate  = r_in.rate_x;
                cur_store = r_roll;
                cur_acc   = r_roll_acc;
            end
            AX_PITCH: begin
                cur_rate  = r_in.rate_y;
                cur_store = r_pitch;
                cur_acc   = r_pitch_acc;
            end
            default: begin
                cur_rate  = r_in.rate_z;
                cur_store = r_yaw;
                cur_acc   = 32'sd0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_started   = r_started;
        n_first     = r_first;
        n_roll      = r_roll;
        n_pitch     = r_pitch;
        n_yaw       = r_yaw;
        n_roll_acc  = r_roll_acc;
        n_pitch_acc = r_pitch_acc;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_czero     = r_czero;
        n_step      = r_step;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_sq_cnt    = r_sq_cnt;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_axis      = r_axis;
        n_phase     = r_phase;
        mul_a       = '0;
        mul_b       = '0;
        seed        = cordic_seed({r_in.accel_y[15], r_in.accel_y},
                                  {r_in.accel_z[15], r_in.accel_z});

        // CORDIC rotation, advance until the step count is reached
        if ((r_state inside {ST_ROLL, ST_PITCH}) && !crd_done) begin
            if (!r_cy[CRD_W-1]) begin
                n_cx = r_cx + cy_sh;
                n_cy = r_cy - cx_sh;
                n_cz = r_cz + crd_tab;
            end else begin
                n_cx = r_cx - cy_sh;
                n_cy = r_cy + cx_sh;
                n_cz = r_cz - crd_tab;
            end
            n_step = r_step + 1'b1;
        end

        // square root runs beside the roll pass
        if (r_state == ST_ROLL && !sq_done) begin
            if (sq_cand >= sq_trial) begin
                n_rem  = REM_W'(sq_cand - sq_trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(sq_cand);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_rad    = {r_rad[RAD_W-3:0], 2'b00};
            n_sq_cnt = r_sq_cnt - 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_in    = i_sample.data;
                    n_state = ST_MAG0;
                end
            end
            ST_MAG0: begin
                mul_a   = MUL_A_W'(r_in.accel_y);
                mul_b   = MUL_B_W'(r_in.accel_y);
                n_state = ST_MAG1;
            end
            ST_MAG1: begin
                n_acc   = $signed(r_mul[ACC_W-1:0]);
                mul_a   = MUL_A_W'(r_in.accel_z);
                mul_b   = MUL_B_W'(r_in.accel_z);
                n_state = ST_MAG2;
            end
            ST_MAG2: begin
                n_rad    = r_acc[RAD_W-1:0] + r_mul[RAD_W-1:0];
                n_rem    = '0;
                n_root   = '0;
                n_sq_cnt = SQ_STEPS;
                n_cx     = seed.x;
                n_cy     = seed.y;
                n_cz     = seed.z;
                n_czero  = seed.zero;
                n_step   = '0;
                n_state  = ST_ROLL;
            end
            ST_ROLL: begin
                if (crd_done && sq_done) begin
                    seed       = cordic_seed(-{r_in.accel_x[15], r_in.accel_x},
                                             {1'b0, r_root});
                    n_roll_acc = crd_res;
                    n_cx       = seed.x;
                    n_cy       = seed.y;
                    n_cz       = seed.z;
                    n_czero    = seed.zero;
                    n_step     = '0;
                    n_state    = ST_PITCH;
                end
            end
            ST_PITCH: begin
                if (crd_done) begin
                    n_pitch_acc = crd_res;
                    if (!r_started) begin
                        n_roll    = r_roll_acc;
                        n_pitch   = crd_res;
                        n_yaw     = '0;
                        n_started = 1'b1;
                        n_first   = 1'b1;
                        n_state   = ST_OUT;
                    end else begin
                        n_first   = 1'b0;
                        n_axis    = AX_ROLL;
                        n_phase   = PH_RATE;
                        n_state   = ST_BLEND;
                    end
                end
            end
            ST_BLEND: begin
                case (r_phase)
                    PH_RATE: begin
                        mul_a   = MUL_A_W'(cur_rate);
                        mul_b   = MUL_B_W'(r_in.step_time);
                        n_phase = PH_SCALE;
                    end
                    PH_SCALE: begin
                        mul_a   = MUL_A_W'($signed(r_mul[31:0]));
                        mul_b   = RAD2DEG_Q24;
                        n_phase = PH_SUM;
                    end
                    PH_SUM: begin
                        n_sum = store_sum;
                        if (r_axis == AX_YAW) begin
                            n_yaw   = sat32(ACC_W'(store_sum));
                            n_state = ST_OUT;
                        end else begin
                            n_phase = PH_WEIGHT;
                        end
                    end
                    PH_WEIGHT: begin
                        mul_a   = MUL_A_W'(r_sum);
                        mul_b   = MUL_B_W'(r_alpha);
                        n_phase = PH_MIX;
                    end
                    PH_MIX: begin
                        n_acc   = $signed(r_mul[ACC_W-1:0] + MIX_RND);
                        mul_a   = MUL_A_W'(cur_acc);
                        mul_b   = MUL_B_W'(ALPHA_ONE - 17'(r_alpha));
                        n_phase = PH_ROUND;
                    end
                    PH_ROUND: begin
                        n_phase = PH_RATE;
                        if (r_axis == AX_ROLL) begin
                            n_roll = sat32(mix);
                            n_axis = AX_PITCH;
                        end else begin
                            n_pitch = sat32(mix);
                            n_axis  = AX_YAW;
                        end
                    end
                    default: begin
                        n_phase = PH_RATE;
                    end
                endcase
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alpha     <= ALPHA_RESET;
            r_started   <= 1'b0;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_roll    <= n_roll;
            r_pitch   <= n_pitch;
            r_yaw     <= n_yaw;
            if (i_cfg.valid && i_cfg.ready) begin
                r_alpha <= i_cfg.data;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_first     <= n_first;
        r_roll_acc  <= n_roll_acc;
        r_pitch_acc <= n_pitch_acc;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_cz        <= n_cz;
        r_czero     <= n_czero;
        r_step      <= n_step;
        r_rad       <= n_rad;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_sq_cnt    <= n_sq_cnt;
        r_mul       <= mul_p;
        r_acc       <= n_acc;
        r_sum       <= n_sum;
        r_axis      <= n_axis;
        r_phase     <= n_phase;
        if (r_state == ST_OUT && out_free) begin
            r_out.roll_angle  <= r_roll;
            r_out.pitch_angle <= r_pitch;
            r_out.yaw_angle   <= r_yaw;
            r_out.was_first   <= r_first;
        end
    end

    `ICF_ASSERT_NEXT(a_busy_after_xfer, i_sample.valid && i_sample.ready, !i_sample.ready)
    `ICF_ASSERT_IMPL(a_out_from_final, $rose(o_result.valid), $past(r_state) == ST_OUT)
    `ICF_ASSERT_IMPL(a_first_zero_yaw, r_out_valid && r_out.was_first, r_out.yaw_angle == 0)

endmodule
